>>> rtl/multilevel_surface_cell_update_unit_assert.svh
// ---------------------------------------------------------------------------
// Surface cell update: assertion macros
// Concurrent checks on clock, disabled during reset; ASSERT_OFF removes them.
// ---------------------------------------------------------------------------
`ifndef MULTILEVEL_SURFACE_CELL_UPDATE_UNIT_ASSERT_SVH
`define MULTILEVEL_SURFACE_CELL_UPDATE_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define MSC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("surface cell update check failed");
`define MSC_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("surface cell update forbidden condition");
`else
`define MSC_ASSERT(lbl, prop)
`define MSC_NEVER(lbl, cond)
`endif

`endif

>>> rtl/msc_pkg.sv
// ---------------------------------------------------------------------------
// Surface cell update package
// Shared constants, patch record, command and status bundles, state codes.
// ---------------------------------------------------------------------------
package msc_pkg;

   localparam int DEF_GRID_WIDTH  = 64;
   localparam int DEF_GRID_HEIGHT = 64;
   localparam int DEF_MAX_PATCHES = 4;

   localparam logic [30:0] GAP_RESET   = 31'd65536;
   localparam logic [30:0] THICK_RESET = 31'd6554;
   localparam logic [30:0] EXT_MAX     = 31'h7FFF_FFFF;
   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [64:0] ROUND_Q30   = 65'h2000_0000;

   localparam int DIV_STEPS  = 31;
   localparam int SQRT_STEPS = 16;

   typedef enum logic [0:0] {
      CSR_GAP_SIZE  = 1'b0,
      CSR_THICKNESS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      OUT_FUSED    = 3'd0,
      OUT_RAISED   = 3'd1,
      OUT_EXTENDED = 3'd2,
      OUT_NEW      = 3'd3,
      OUT_DROPPED  = 3'd4
   } outcome_type;

   typedef struct packed {
      logic signed [31:0] mean;
      logic [15:0]        stdev;
      logic [30:0]        extent;
      logic               flat;
   } patch_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_RD_FILL,
      ST_GET_FILL,
      ST_RD_PATCH,
      ST_CHK_PATCH,
      ST_NO_MATCH,
      ST_VERT,
      ST_F_SQUARE,
      ST_F_SUM,
      ST_F_DIV,
      ST_F_DIV_WAIT,
      ST_F_MUL_GAIN,
      ST_F_MEAN,
      ST_F_MUL_VAR,
      ST_F_SQRT,
      ST_F_SQRT_WAIT,
      ST_F_STDEV,
      ST_WRITE,
      ST_DROP,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic        load_req;
      logic        clr_step;
      logic        load_fill;
      logic        k_dec;
      logic        load_patch;
      logic        new_patch;
      logic        vert_upd;
      logic        f_square;
      logic        f_sum;
      logic        div_start;
      logic        mul_gain;
      logic        mean_upd;
      logic        mul_var;
      logic        sqrt_start;
      logic        stdev_upd;
      logic        wr_patch;
      logic        wr_fill;
      logic        set_outcome;
      outcome_type outcome;
      logic        out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic clr_done;
      logic in_range;
      logic fill_zero;
      logic fill_full;
      logic k_zero;
      logic match;
      logic fuse_ok;
      logic above;
      logic iter_busy;
      logic rsp_busy;
   } dp_status_type;

endpackage

>>> rtl/msc_iter.sv
// ---------------------------------------------------------------------------
// Surface cell update: shared iterative unit
// Restoring divider (one quotient bit a cycle) and integer square root
// (one root bit a cycle) on a shared step counter.
// ---------------------------------------------------------------------------
`include "multilevel_surface_cell_update_unit_assert.svh"

module msc_iter import msc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        div_start,
   input  logic        sqrt_start,
   input  logic [62:0] num,
   input  logic [32:0] den,
   input  logic [31:0] rad,
   output logic        busy,
   output logic [30:0] quo,
   output logic [15:0] root
);

   logic        busy_ff, busy_in;
   logic        mode_sqrt_ff, mode_sqrt_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [33:0] rem_ff;
   logic [30:0] q_ff;
   logic [32:0] den_ff;
   logic [31:0] rad_ff;
   logic [15:0] root_ff;
   logic [18:0] srem_ff;

   logic [33:0] div_t;
   logic        div_ge;
   logic [18:0] sq_t;
   logic [18:0] sq_trial;
   logic        sq_ge;
   logic        last_step;

   assign div_t    = {rem_ff[32:0], q_ff[30]};
   assign div_ge   = div_t >= {1'b0, den_ff};
   assign sq_t     = {srem_ff[16:0], rad_ff[31:30]};
   assign sq_trial = {1'b0, root_ff, 2'b01};
   assign sq_ge    = sq_t >= sq_trial;
   assign last_step = mode_sqrt_ff ? (cnt_ff == 5'(SQRT_STEPS - 1))
                                   : (cnt_ff == 5'(DIV_STEPS - 1));

   always_comb begin
      busy_in      = busy_ff;
      mode_sqrt_in = mode_sqrt_ff;
      cnt_in       = cnt_ff;
      if (div_start || sqrt_start) begin
         busy_in      = 1'b1;
         mode_sqrt_in = sqrt_start;
         cnt_in       = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 5'd1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         mode_sqrt_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         mode_sqrt_ff <= mode_sqrt_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (div_start) begin
         rem_ff <= {2'b00, num[62:31]};
         q_ff   <= num[30:0];
         den_ff <= den;
      end else if (busy_ff && !mode_sqrt_ff) begin
         rem_ff <= div_ge ? (div_t - {1'b0, den_ff}) : div_t;
         q_ff   <= {q_ff[29:0], div_ge};
      end
      if (sqrt_start) begin
         rad_ff  <= rad;
         root_ff <= '0;
         srem_ff <= '0;
      end else if (busy_ff && mode_sqrt_ff) begin
         rad_ff  <= {rad_ff[29:0], 2'b00};
         srem_ff <= sq_ge ? (sq_t - sq_trial) : sq_t;
         root_ff <= {root_ff[14:0], sq_ge};
      end
   end

   assign busy = busy_ff;
   assign quo  = q_ff;
   assign root = root_ff;

   // gain never exceeds one when the divisor is nonzero
   `MSC_ASSERT(a_gain_range, $fell(busy_ff) && !mode_sqrt_ff && den_ff != '0 |-> q_ff <= ONE_Q30)
   `MSC_NEVER(a_start_busy, (div_start || sqrt_start) && busy_ff)

endmodule

>>> rtl/msc_datapath.sv
// ---------------------------------------------------------------------------
// Surface cell update: datapath
// Configuration, item registers, fill and patch memories, patch match and
// update arithmetic, shared multiplier, result register.
// ---------------------------------------------------------------------------
`include "multilevel_surface_cell_update_unit_assert.svh"

module msc_datapath import msc_pkg::*; #(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
   parameter int MAX_PATCHES = DEF_MAX_PATCHES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [0:0]         csr_index,
   input  logic [30:0]        csr_wdata,
   input  logic [5:0]         req_cell_x,
   input  logic [5:0]         req_cell_y,
   input  logic signed [31:0] req_meas_height,
   input  logic [15:0]        req_meas_stdev,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_outcome,
   output logic [1:0]         rsp_patch_slot,
   output logic signed [31:0] rsp_patch_mean,
   output logic [15:0]        rsp_patch_stdev,
   output logic [30:0]        rsp_patch_extent,
   output logic               rsp_patch_flat,
   input  dp_cmd_type         cmd,
   output dp_status_type      st
);

   localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
   localparam int CELL_W = $clog2(CELLS);
   localparam int SLOT_W = (MAX_PATCHES > 1) ? $clog2(MAX_PATCHES) : 1;
   localparam int FILL_W = $clog2(MAX_PATCHES + 1);
   localparam int PDEPTH = CELLS << SLOT_W;

   logic [30:0] gap_ff, thick_ff;

   logic [CELL_W-1:0]  cell_ff, cell_in;
   logic               in_range_ff, in_range_in;
   logic signed [31:0] h_ff;
   logic [15:0]        s_ff;
   logic signed [33:0] hpg_ff, hmg_ff, hpt_ff, hmt_ff;

   logic [FILL_W-1:0] fill_mem [0:CELLS-1];
   logic [FILL_W-1:0] fill_rd_ff;
   logic [FILL_W-1:0] n_ff;
   logic [SLOT_W-1:0] k_ff;
   logic [CELL_W-1:0] clr_cnt_ff;

   patch_type         patch_mem [0:PDEPTH-1];
   patch_type         patch_rd_ff;
   patch_type         wp_ff;
   logic [SLOT_W-1:0] slot_ff;
   outcome_type       outcome_ff;

   logic [31:0] pv_ff, mv_ff;
   logic [32:0] sum_ff;
   logic        d_neg_ff;
   logic [32:0] mag_ff;
   logic [64:0] prod_ff;

   logic        rsp_valid_ff;
   logic [2:0]  rsp_outcome_ff;
   logic [1:0]  rsp_slot_ff;
   logic signed [31:0] rsp_mean_ff;
   logic [15:0] rsp_stdev_ff;
   logic [30:0] rsp_extent_ff;
   logic        rsp_flat_ff;

   logic        iter_busy;
   logic [30:0] quo;
   logic [15:0] root;
   logic [62:0] div_num;
   logic [31:0] sqrt_rad;
   logic [30:0] gain;
   logic [30:0] one_minus_gain;
   logic [32:0] mul_a;
   logic [31:0] mul_b;

   logic signed [34:0] rd_mean, rd_ext;
   logic signed [33:0] wp_mean34, h34, diff34;
   logic [33:0]        raise_ext;
   logic [33:0]        ext_pick;
   logic signed [32:0] d33;
   logic [32:0]        mean_step;
   logic signed [33:0] mean_new;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         gap_ff   <= GAP_RESET;
         thick_ff <= THICK_RESET;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_GAP_SIZE:  gap_ff   <= csr_wdata;
            CSR_THICKNESS: thick_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign in_range_in = (13'(req_cell_x) < 13'(GRID_WIDTH)) &&
                        (13'(req_cell_y) < 13'(GRID_HEIGHT));
   assign cell_in = CELL_W'(CELL_W'(req_cell_y) * CELL_W'(GRID_WIDTH)) +
                    CELL_W'(req_cell_x);

   // item registers; match bands are folded around the height up front
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         cell_ff     <= cell_in;
         in_range_ff <= in_range_in;
         h_ff        <= req_meas_height;
         s_ff        <= req_meas_stdev;
         hpg_ff      <= 34'(req_meas_height) + 34'(gap_ff);
         hmg_ff      <= 34'(req_meas_height) - 34'(gap_ff);
         hpt_ff      <= 34'(req_meas_height) + 34'(thick_ff);
         hmt_ff      <= 34'(req_meas_height) - 34'(thick_ff);
      end
   end

   // fill counts: clearing sweep after reset, one cell a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr_step) begin
         clr_cnt_ff <= clr_cnt_ff + CELL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step) begin
         fill_mem[clr_cnt_ff] <= '0;
      end else if (cmd.wr_fill) begin
         fill_mem[cell_ff] <= n_ff + FILL_W'(1);
      end
      fill_rd_ff <= fill_mem[cell_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_patch) begin
         patch_mem[{cell_ff, slot_ff}] <= wp_ff;
      end
      patch_rd_ff <= patch_mem[{cell_ff, k_ff}];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_fill) begin
         n_ff <= fill_rd_ff;
         k_ff <= SLOT_W'(fill_rd_ff - FILL_W'(1));
      end else if (cmd.k_dec) begin
         k_ff <= k_ff - SLOT_W'(1);
      end
   end

   // match tests on the patch just read
   assign rd_mean = 35'(patch_rd_ff.mean);
   assign rd_ext  = signed'({4'b0000, patch_rd_ff.extent});

   // vertical update
   assign wp_mean34 = 34'(wp_ff.mean);
   assign h34       = 34'(h_ff);
   assign diff34    = h34 - wp_mean34;
   assign raise_ext = {3'b000, wp_ff.extent} + 34'(diff34);
   assign ext_pick  = (34'(-diff34) > {3'b000, wp_ff.extent}) ? 34'(-diff34)
                                                              : {3'b000, wp_ff.extent};

   // fusion
   assign d33            = 33'(h_ff) - 33'(wp_ff.mean);
   assign div_num        = {pv_ff[31:0], 30'b0} + 63'(sum_ff >> 1);
   assign gain           = (sum_ff == '0) ? '0 : quo;
   assign one_minus_gain = ONE_Q30 - gain;
   assign mul_a          = cmd.mul_var ? 33'(one_minus_gain) : mag_ff;
   assign mul_b          = cmd.mul_var ? pv_ff : 32'(gain);
   assign mean_step      = 33'((prod_ff + ROUND_Q30) >> 30);
   assign mean_new       = d_neg_ff ? (wp_mean34 - 34'(mean_step))
                                    : (wp_mean34 + 34'(mean_step));
   assign sqrt_rad       = 32'((prod_ff + ROUND_Q30) >> 30);

   msc_iter u_iter (
      .clock      (clock),
      .reset      (reset),
      .div_start  (cmd.div_start),
      .sqrt_start (cmd.sqrt_start),
      .num        (div_num),
      .den        (sum_ff),
      .rad        (sqrt_rad),
      .busy       (iter_busy),
      .quo        (quo),
      .root       (root)
   );

   always_ff @(posedge clock) begin
      if (cmd.f_square) begin
         pv_ff    <= 32'(wp_ff.stdev) * 32'(wp_ff.stdev);
         mv_ff    <= 32'(s_ff) * 32'(s_ff);
         d_neg_ff <= d33[32];
         mag_ff   <= d33[32] ? 33'(-d33) : 33'(d33);
      end
      if (cmd.f_sum) begin
         sum_ff <= 33'(pv_ff) + 33'(mv_ff);
      end
      if (cmd.mul_gain || cmd.mul_var) begin
         prod_ff <= 65'(mul_a) * 65'(mul_b);
      end
   end

   // working patch
   always_ff @(posedge clock) begin
      if (cmd.load_patch) begin
         wp_ff   <= patch_rd_ff;
         slot_ff <= k_ff;
      end else if (cmd.new_patch) begin
         wp_ff.mean   <= h_ff;
         wp_ff.stdev  <= s_ff;
         wp_ff.extent <= '0;
         wp_ff.flat   <= 1'b1;
         slot_ff      <= SLOT_W'(n_ff);
      end else if (cmd.vert_upd) begin
         wp_ff.flat <= 1'b0;
         if (diff34 > 34'sd0) begin
            wp_ff.mean   <= h_ff;
            wp_ff.stdev  <= s_ff;
            wp_ff.extent <= (raise_ext > 34'(EXT_MAX)) ? EXT_MAX : 31'(raise_ext);
         end else begin
            wp_ff.extent <= (ext_pick > 34'(EXT_MAX)) ? EXT_MAX : 31'(ext_pick);
         end
      end else if (cmd.mean_upd) begin
         wp_ff.mean <= 32'(mean_new);
      end else if (cmd.stdev_upd) begin
         wp_ff.stdev <= root;
      end
      if (cmd.set_outcome) begin
         outcome_ff <= cmd.outcome;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_outcome_ff <= outcome_ff;
         if (outcome_ff == OUT_DROPPED) begin
            rsp_slot_ff   <= '0;
            rsp_mean_ff   <= '0;
            rsp_stdev_ff  <= '0;
            rsp_extent_ff <= '0;
            rsp_flat_ff   <= 1'b0;
         end else begin
            rsp_slot_ff   <= 2'(slot_ff);
            rsp_mean_ff   <= wp_ff.mean;
            rsp_stdev_ff  <= wp_ff.stdev;
            rsp_extent_ff <= wp_ff.extent;
            rsp_flat_ff   <= wp_ff.flat;
         end
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_outcome      = rsp_outcome_ff;
   assign rsp_patch_slot   = rsp_slot_ff;
   assign rsp_patch_mean   = rsp_mean_ff;
   assign rsp_patch_stdev  = rsp_stdev_ff;
   assign rsp_patch_extent = rsp_extent_ff;
   assign rsp_patch_flat   = rsp_flat_ff;

   always_comb begin
      st.clr_done  = clr_cnt_ff == CELL_W'(CELLS - 1);
      st.in_range  = in_range_ff;
      st.fill_zero = fill_rd_ff == '0;
      st.fill_full = n_ff >= FILL_W'(MAX_PATCHES);
      st.k_zero    = k_ff == '0;
      st.match     = (rd_mean < 35'(hpg_ff) + rd_ext) && (rd_mean > 35'(hmg_ff));
      st.fuse_ok   = patch_rd_ff.flat && (rd_mean < 35'(hpt_ff) + rd_ext) &&
                     (rd_mean > 35'(hmt_ff));
      st.above     = diff34 > 34'sd0;
      st.iter_busy = iter_busy;
      st.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   `MSC_ASSERT(a_fill_bound, cmd.wr_fill |-> n_ff < FILL_W'(MAX_PATCHES))

endmodule

>>> rtl/msc_ctrl.sv
// ---------------------------------------------------------------------------
// Surface cell update: controller
// Sequences the map clear, patch walk, update paths and result hand-off.
// ---------------------------------------------------------------------------
`include "multilevel_surface_cell_update_unit_assert.svh"

module msc_ctrl import msc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output dp_cmd_type    cmd,
   input  dp_status_type st
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:       if (st.clr_done) state_in = ST_IDLE;
         ST_IDLE:        if (req_valid) state_in = ST_RD_FILL;
         ST_RD_FILL:     state_in = ST_GET_FILL;
         ST_GET_FILL: begin
            if (!st.in_range) state_in = ST_DROP;
            else if (st.fill_zero) state_in = ST_NO_MATCH;
            else state_in = ST_RD_PATCH;
         end
         ST_RD_PATCH:    state_in = ST_CHK_PATCH;
         ST_CHK_PATCH: begin
            if (st.match) state_in = st.fuse_ok ? ST_F_SQUARE : ST_VERT;
            else if (st.k_zero) state_in = ST_NO_MATCH;
            else state_in = ST_RD_PATCH;
         end
         ST_NO_MATCH:    state_in = st.fill_full ? ST_DROP : ST_WRITE;
         ST_VERT:        state_in = ST_WRITE;
         ST_F_SQUARE:    state_in = ST_F_SUM;
         ST_F_SUM:       state_in = ST_F_DIV;
         ST_F_DIV:       state_in = ST_F_DIV_WAIT;
         ST_F_DIV_WAIT:  if (!st.iter_busy) state_in = ST_F_MUL_GAIN;
         ST_F_MUL_GAIN:  state_in = ST_F_MEAN;
         ST_F_MEAN:      state_in = ST_F_MUL_VAR;
         ST_F_MUL_VAR:   state_in = ST_F_SQRT;
         ST_F_SQRT:      state_in = ST_F_SQRT_WAIT;
         ST_F_SQRT_WAIT: if (!st.iter_busy) state_in = ST_F_STDEV;
         ST_F_STDEV:     state_in = ST_WRITE;
         ST_WRITE:       state_in = ST_OUT;
         ST_DROP:        state_in = ST_OUT;
         ST_OUT:         if (!st.rsp_busy) state_in = ST_IDLE;
         default:        state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_CLEAR: cmd.clr_step = 1'b1;
         ST_IDLE: begin
            req_ready    = 1'b1;
            cmd.load_req = req_valid;
         end
         ST_GET_FILL: cmd.load_fill = st.in_range;
         ST_CHK_PATCH: begin
            cmd.load_patch = 1'b1;
            cmd.k_dec      = !st.match && !st.k_zero;
            if (st.match && st.fuse_ok) begin
               cmd.set_outcome = 1'b1;
               cmd.outcome     = OUT_FUSED;
            end
         end
         ST_NO_MATCH: begin
            // append a fresh flat patch unless the cell is full
            cmd.new_patch   = !st.fill_full;
            cmd.wr_fill     = !st.fill_full;
            cmd.set_outcome = !st.fill_full;
            cmd.outcome     = OUT_NEW;
         end
         ST_VERT: begin
            cmd.vert_upd    = 1'b1;
            cmd.set_outcome = 1'b1;
            cmd.outcome     = st.above ? OUT_RAISED : OUT_EXTENDED;
         end
         ST_F_SQUARE:   cmd.f_square   = 1'b1;
         ST_F_SUM:      cmd.f_sum      = 1'b1;
         ST_F_DIV:      cmd.div_start  = 1'b1;
         ST_F_MUL_GAIN: cmd.mul_gain   = 1'b1;
         ST_F_MEAN:     cmd.mean_upd   = 1'b1;
         ST_F_MUL_VAR:  cmd.mul_var    = 1'b1;
         ST_F_SQRT:     cmd.sqrt_start = 1'b1;
         ST_F_STDEV:    cmd.stdev_upd  = 1'b1;
         ST_WRITE:      cmd.wr_patch   = 1'b1;
         ST_DROP: begin
            cmd.set_outcome = 1'b1;
            cmd.outcome     = OUT_DROPPED;
         end
         ST_OUT: cmd.out_load = !st.rsp_busy;
         default: ;
      endcase
   end

   `MSC_ASSERT(a_accept_seq, req_valid && req_ready |=> state_ff == ST_RD_FILL)
   `MSC_ASSERT(a_div_busy, state_ff == ST_F_DIV |=> st.iter_busy)

endmodule

>>> rtl/multilevel_surface_cell_update_unit.sv
// ---------------------------------------------------------------------------
// Multilevel surface cell update unit
// Updates the surface patches of one grid cell with one height measurement.
// ---------------------------------------------------------------------------
//  channel  ports     handshake            content
//  request  req_*     req_valid/req_ready  cell x, y, height, stdev
//  result   rsp_*     rsp_valid/rsp_ready  outcome, slot, updated patch
//  config   csr_*     csr_wr_en            gap_size (0), thickness (1)
//
//  One item at a time. Each item reads its cell's fill count and walks the
//  cell's patches (each patch walked is one read of the patch memory and one
//  compare) before a new patch, a full-cell drop, a vertical update or a
//  fusion; an out-of-range cell drops without a walk. Fusion runs the 31-step
//  divider and the 16-step square root. After reset a clearing pass writes
//  all GRID_WIDTH*GRID_HEIGHT fill counts with req_ready low. A finished item
//  waits in the controller until the output register is free or being
//  drained; the next item can be accepted in the cycle after it moves there.
// ---------------------------------------------------------------------------
module multilevel_surface_cell_update_unit import msc_pkg::*; #(
   parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
   parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
   parameter int MAX_PATCHES = DEF_MAX_PATCHES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [0:0]         csr_index,
   input  logic [30:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [5:0]         req_cell_x,
   input  logic [5:0]         req_cell_y,
   input  logic signed [31:0] req_meas_height,
   input  logic [15:0]        req_meas_stdev,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_outcome,
   output logic [1:0]         rsp_patch_slot,
   output logic signed [31:0] rsp_patch_mean,
   output logic [15:0]        rsp_patch_stdev,
   output logic [30:0]        rsp_patch_extent,
   output logic               rsp_patch_flat
);

   dp_cmd_type    cmd;
   dp_status_type st;

   msc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .st        (st)
   );

   msc_datapath #(
      .GRID_WIDTH  (GRID_WIDTH),
      .GRID_HEIGHT (GRID_HEIGHT),
      .MAX_PATCHES (MAX_PATCHES)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_cell_x       (req_cell_x),
      .req_cell_y       (req_cell_y),
      .req_meas_height  (req_meas_height),
      .req_meas_stdev   (req_meas_stdev),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_outcome      (rsp_outcome),
      .rsp_patch_slot   (rsp_patch_slot),
      .rsp_patch_mean   (rsp_patch_mean),
      .rsp_patch_stdev  (rsp_patch_stdev),
      .rsp_patch_extent (rsp_patch_extent),
      .rsp_patch_flat   (rsp_patch_flat),
      .cmd              (cmd),
      .st               (st)
   );

endmodule
